/* sv/assert_macros.svh */
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* sv/slcd_pkg.sv */
// Types and constants of the sync/length/checksum deframer.
package slcd_pkg;

	localparam int BUFFER_BYTES_DEF = 25;
	localparam int JOB_DEPTH_DEF    = 2;
	localparam int HDR_BYTES        = 4;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h55;
	localparam logic [7:0] SYNC_SECOND_RST = 8'hAA;

	// Configuration register indexes.
	localparam logic CFG_SYNC_FIRST  = 1'b0;
	localparam logic CFG_SYNC_SECOND = 1'b1;

	// Parser phases: store index of the next expected frame byte.
	localparam int PH_SYNC1 = 0;
	localparam int PH_SYNC2 = 1;
	localparam int PH_CMD   = 2;
	localparam int PH_COUNT = 3;
	localparam int PH_DATA  = 4;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SHOW
	} back_state_t;

endpackage

/* sv/slcd_front.sv */
// Front end: frame parser, running checksum and frame store write port.
`include "assert_macros.svh"

module slcd_front #(
	parameter int BUFFER_BYTES = slcd_pkg::BUFFER_BYTES_DEF,
	parameter int AW           = $clog2(BUFFER_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    rx_byte,
	input  logic          line_error,
	input  logic          hold,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic          job_push,
	output logic [AW-1:0] job_end
);
	import slcd_pkg::*;

	logic [7:0]    sync_first_q;
	logic [7:0]    sync_second_q;
	logic [AW-1:0] phase_q, phase_d;
	logic [AW-1:0] end_q, end_d;
	logic [7:0]    sum_q, sum_d;
	logic [8:0]    end_w;
	logic          accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// While a frame is replayed, only the sync bytes may be taken, since
	// they land outside the body area of the store.
	assign in_ready = !hold || (phase_q < AW'(PH_CMD));
	assign accept   = in_valid && in_ready;
	assign end_w    = {1'b0, rx_byte} + 9'(HDR_BYTES);

	assign wr_en   = accept && !line_error;
	assign wr_addr = phase_q;
	assign wr_data = rx_byte;
	assign job_end = end_q;

	always_comb begin
		phase_d  = phase_q;
		end_d    = end_q;
		sum_d    = sum_q;
		job_push = 1'b0;
		if (accept) begin
			if (line_error) begin
				phase_d = AW'(PH_SYNC1);
			end else begin
				case (phase_q)
					AW'(PH_SYNC1): begin
						if (rx_byte == sync_first_q) phase_d = AW'(PH_SYNC2);
					end
					AW'(PH_SYNC2): begin
						if (rx_byte == sync_second_q) phase_d = AW'(PH_CMD);
					end
					AW'(PH_CMD): begin
						sum_d   = rx_byte;
						phase_d = AW'(PH_COUNT);
					end
					AW'(PH_COUNT): begin
						if (end_w >= 9'(BUFFER_BYTES)) begin
							phase_d = AW'(PH_SYNC1);
						end else begin
							end_d   = end_w[AW-1:0];
							sum_d   = sum_q + rx_byte;
							phase_d = AW'(PH_DATA);
						end
					end
					default: begin
						if (phase_q < end_q) begin
							sum_d   = sum_q + rx_byte;
							phase_d = phase_q + AW'(1);
						end else begin
							// Checksum byte: good or bad, the next frame starts over.
							job_push = (rx_byte == sum_q);
							phase_d  = AW'(PH_SYNC1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			end_q   <= '0;
		end else begin
			phase_q <= phase_d;
			end_q   <= end_d;
		end
	end

	always_ff @(posedge clk) begin
		sum_q <= sum_d;
	end

	`ASSERT_AT(a_front_no_body_write_on_hold, clk, arst_n,
		(wr_en && hold) |-> (wr_addr < AW'(PH_CMD)), "body written during replay")

endmodule

/* sv/slcd_fifo.sv */
// Short job queue between the parser and the replay engine.
`include "assert_macros.svh"

module slcd_fifo #(
	parameter int DEPTH = slcd_pkg::JOB_DEPTH_DEF,
	parameter int W     = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty,
	output logic         full
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_NEVER(a_fifo_push_full, clk, arst_n, push && full, "job queue overflow")
	`ASSERT_NEVER(a_fifo_pop_empty, clk, arst_n, pop && empty, "job queue underflow")

endmodule

/* sv/slcd_back.sv */
// Back end: frame store memory and replay of an accepted frame body.
`include "assert_macros.svh"

module slcd_back #(
	parameter int BUFFER_BYTES = slcd_pkg::BUFFER_BYTES_DEF,
	parameter int AW           = $clog2(BUFFER_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          job_valid,
	input  logic [AW-1:0] job_end,
	output logic          job_pop,
	output logic          busy,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    body_byte,
	output logic [4:0]    position,
	output logic          last
);
	import slcd_pkg::*;

	logic [7:0]    store_q [BUFFER_BYTES];
	logic [7:0]    rd_q;
	back_state_t   state_q, state_d;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] end_q;
	logic [4:0]    pos_q;
	logic          is_last;

	assign is_last = ({1'b0, addr_q} + (AW + 1)'(1)) == {1'b0, end_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (state_q == BK_READ) begin
			rd_q <= store_q[addr_q];
		end
	end

	always_comb begin
		state_d   = state_q;
		job_pop   = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: begin
				state_d = BK_SHOW;
			end
			BK_SHOW: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = is_last ? BK_IDLE : BK_READ;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			end_q  <= job_end;
			addr_q <= AW'(PH_CMD);
			pos_q  <= '0;
		end else if (state_q == BK_SHOW && out_ready && !is_last) begin
			addr_q <= addr_q + AW'(1);
			pos_q  <= pos_q + 5'd1;
		end
	end

	assign busy      = (state_q != BK_IDLE);
	assign body_byte = rd_q;
	assign position  = pos_q;
	assign last      = is_last;

	`ASSERT_AT(a_back_pop_starts_read, clk, arst_n,
		job_pop |=> (state_q == BK_READ), "job taken but no replay started")

endmodule

/* sv/sync_length_checksum_deframer.sv */
// Top level of the sync/length/checksum frame deframer.
// Input channel (in_valid/in_ready) takes one received byte per transfer with
// its line_error flag. The parser hunts for the two sync bytes, then takes a
// command, a count n, n data bytes and an additive checksum byte.
// Output channel (out_valid/out_ready) gives the body of every frame whose
// checksum matches: command, count and data, with position and a last flag.
// A bad frame, an oversized count or a line error gives no output.
// The parser takes input bytes without a stall while no job waits or runs.
// A good checksum byte queues the frame as a job; the replay engine pops it
// and, through the single read port of the frame store, reads each body
// byte in BK_READ and shows it in BK_SHOW until it is transferred. While a
// job waits or runs, the parser takes sync bytes but holds in_ready low at
// the command byte of the next frame until the last body byte is transferred.
// A stalled receiver holds the current body byte and freezes the replay.
// Reset restores the sync registers to 0x55 and 0xAA and returns the parser
// to hunting; the frame store is not cleared and needs no clearing pass.
// cfg_we writes cfg_data to the register chosen by cfg_index at once.
`include "assert_macros.svh"

module sync_length_checksum_deframer #(
	parameter int BUFFER_BYTES = slcd_pkg::BUFFER_BYTES_DEF,
	parameter int JOB_DEPTH    = slcd_pkg::JOB_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       line_error,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] body_byte,
	output logic [4:0] position,
	output logic       last
);
	import slcd_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          job_push;
	logic [AW-1:0] job_end_front;
	logic          job_pop;
	logic [AW-1:0] job_end_back;
	logic          job_empty;
	logic          job_full;
	logic          back_busy;
	logic          hold;

	// Body area of the store is owned by the back end while a job waits or runs.
	assign hold = !job_empty || back_busy;

	slcd_front #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.line_error(line_error),
		.hold(hold),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_push(job_push),
		.job_end(job_end_front)
	);

	slcd_fifo #(
		.DEPTH(JOB_DEPTH),
		.W(AW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(job_push),
		.push_data(job_end_front),
		.pop(job_pop),
		.pop_data(job_end_back),
		.empty(job_empty),
		.full(job_full)
	);

	slcd_back #(
		.BUFFER_BYTES(BUFFER_BYTES),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.job_valid(!job_empty),
		.job_end(job_end_back),
		.job_pop(job_pop),
		.busy(back_busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.body_byte(body_byte),
		.position(position),
		.last(last)
	);

	`ASSERT_NEVER(a_top_push_while_held, clk, arst_n, job_push && (hold || job_full),
		"new frame finished while previous one still owns the store")

endmodule
